// File: rtl/bbn_pkg.sv
`default_nettype none

package bbn_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int REG_W           = 31;
	localparam int MUL_CHUNK       = 16;

	localparam logic [REG_W-1:0] TARGET_RESET = 31'd131072;
	localparam logic [REG_W-1:0] MIN_RESET    = 31'd1;

	typedef enum logic {
		REG_TARGET_EXTENT = 1'b0,
		REG_MIN_EXTENT    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_MEAS       = 2'd0,
		CMD_MEAS_END   = 2'd1,
		CMD_XFORM      = 2'd2,
		CMD_XFORM_LAST = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic      valid;
		cmd_kind_t kind;
	} cmd_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bbn_front.sv
`default_nettype none

module bbn_front #(
	parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF,
	parameter int QUEUE_DEPTH = bbn_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic signed [COORD_WIDTH-1:0] x_in,
	input  wire logic signed [COORD_WIDTH-1:0] y_in,
	input  wire logic signed [COORD_WIDTH-1:0] z_in,
	input  wire logic                          end_of_pass,
	input  wire logic                          pop,
	output bbn_pkg::cmd_ctrl_t                 head,
	output logic signed [COORD_WIDTH-1:0]      head_x,
	output logic signed [COORD_WIDTH-1:0]      head_y,
	output logic signed [COORD_WIDTH-1:0]      head_z
);
	import bbn_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_kind_t                        kind_q [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0]    qx_q   [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0]    qy_q   [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0]    qz_q   [QUEUE_DEPTH];
	logic [PTR_W-1:0]                 wr_ptr_q;
	logic [PTR_W-1:0]                 rd_ptr_q;
	logic [CNT_W-1:0]                 count_q;
	logic                             push;
	cmd_kind_t                        kind_in;

	always_comb begin
		unique case ({operation, end_of_pass})
			2'b00:   kind_in = CMD_MEAS;
			2'b01:   kind_in = CMD_MEAS_END;
			2'b10:   kind_in = CMD_XFORM;
			default: kind_in = CMD_XFORM_LAST;
		endcase
	end

	assign busy       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign head.valid = (count_q != '0);
	assign head.kind  = kind_q[rd_ptr_q];
	assign head_x     = qx_q[rd_ptr_q];
	assign head_y     = qy_q[rd_ptr_q];
	assign head_z     = qz_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= kind_in;
			qx_q[wr_ptr_q]   <= x_in;
			qy_q[wr_ptr_q]   <= y_in;
			qz_q[wr_ptr_q]   <= z_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/bbn_engine.sv
`default_nettype none

module bbn_engine #(
	parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = bbn_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bbn_pkg::cmd_ctrl_t            head,
	input  wire logic signed [COORD_WIDTH-1:0] head_x,
	input  wire logic signed [COORD_WIDTH-1:0] head_y,
	input  wire logic signed [COORD_WIDTH-1:0] head_z,
	output logic                               pop,
	output logic                               idle,
	input  wire logic [bbn_pkg::REG_W-1:0]     target_extent,
	input  wire logic [bbn_pkg::REG_W-1:0]     min_extent,
	output logic                               result_valid,
	output logic signed [COORD_WIDTH-1:0]      x_out,
	output logic signed [COORD_WIDTH-1:0]      y_out,
	output logic signed [COORD_WIDTH-1:0]      z_out,
	output logic                               passed_through,
	output logic                               final_vertex
);
	import bbn_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int SW    = REG_W + FB;
	localparam int NCH   = (SW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PW    = NCH * MUL_CHUNK;
	localparam int AW    = CW + PW;
	localparam int RW    = AW - FB;
	localparam int EW    = (CW + 1 > REG_W + 1) ? CW + 1 : REG_W + 1;
	localparam int CNT_W = $clog2(SW + 1);

	localparam logic [RW-1:0] LIM_POS = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [RW-1:0] LIM_NEG = {{(RW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] NEG_MAX = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SPAN = 9'b000000010,
		S_PICK = 9'b000000100,
		S_DIV  = 9'b000001000,
		S_DIFF = 9'b000010000,
		S_ABS  = 9'b000100000,
		S_MUL  = 9'b001000000,
		S_SAT  = 9'b010000000,
		S_EMIT = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	state_t                  state_q;
	axis_t                   axis_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [CW-1:0]    low_x_q, low_y_q, low_z_q;
	logic signed [CW-1:0]    high_x_q, high_y_q, high_z_q;
	logic signed [CW-1:0]    mid_x_q, mid_y_q, mid_z_q;
	logic [SW-1:0]           scale_q;
	logic                    degenerate_q;
	logic signed [CW:0]      span_x_q, span_y_q, span_z_q;
	logic [CW-1:0]           rem_q;
	logic [SW-1:0]           num_q;
	logic [CW-1:0]           div_q;
	logic signed [CW-1:0]    v_x_q, v_y_q, v_z_q;
	logic                    last_q;
	logic signed [CW:0]      d_q;
	logic                    neg_q;
	logic [CW-1:0]           mag_q;
	logic [PW-1:0]           sh_q;
	logic [CW+MUL_CHUNK-1:0] prod_q;
	logic [AW-1:0]           acc_q;
	logic signed [CW-1:0]    res_x_q, res_y_q, res_z_q;
	logic                    result_valid_q;

	logic                    is_xform;
	logic                    is_last;
	logic                    do_clear;
	logic signed [CW:0]      e_xy, e_max;
	logic signed [EW-1:0]    e_ext, min_ext;
	logic                    is_deg;
	logic [CW:0]             div_sh;
	logic                    div_ge;
	logic [CW-1:0]           div_rem;
	logic signed [CW-1:0]    v_sel, m_sel;
	logic [RW-1:0]           r_full, lim, sat;
	logic [CW-1:0]           res;
	logic [MUL_CHUNK-1:0]    chunk;
	axis_t                   axis_nx;

	always_comb begin
		is_xform = (head.kind == CMD_XFORM) || (head.kind == CMD_XFORM_LAST);
		is_last  = (head.kind == CMD_XFORM_LAST);
		pop      = (state_q == S_IDLE) && head.valid;
		idle     = (state_q == S_IDLE);
		do_clear = (pop && is_xform && is_last && degenerate_q) ||
			((state_q == S_EMIT) && last_q);

		e_xy    = (span_y_q > span_x_q) ? span_y_q : span_x_q;
		e_max   = (span_z_q > e_xy) ? span_z_q : e_xy;
		e_ext   = EW'(e_max);
		min_ext = $signed({{(EW-REG_W){1'b0}}, min_extent});
		is_deg  = (e_max <= 0) || (e_ext < min_ext);

		div_sh  = {rem_q, num_q[SW-1]};
		div_ge  = (div_sh >= {1'b0, div_q});
		div_rem = div_ge ? CW'(div_sh - {1'b0, div_q}) : div_sh[CW-1:0];

		unique case (axis_q)
			AX_X: begin
				v_sel   = v_x_q;
				m_sel   = mid_x_q;
				axis_nx = AX_Y;
			end
			AX_Y: begin
				v_sel   = v_y_q;
				m_sel   = mid_y_q;
				axis_nx = AX_Z;
			end
			default: begin
				v_sel   = v_z_q;
				m_sel   = mid_z_q;
				axis_nx = AX_Z;
			end
		endcase

		r_full = acc_q[AW-1:FB];
		lim    = neg_q ? LIM_NEG : LIM_POS;
		sat    = (r_full > lim) ? lim : r_full;
		res    = neg_q ? -sat[CW-1:0] : sat[CW-1:0];
		chunk  = sh_q[PW-1 -: MUL_CHUNK];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			axis_q         <= AX_X;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
			low_x_q        <= POS_MAX;
			low_y_q        <= POS_MAX;
			low_z_q        <= POS_MAX;
			high_x_q       <= NEG_MAX;
			high_y_q       <= NEG_MAX;
			high_z_q       <= NEG_MAX;
			mid_x_q        <= '0;
			mid_y_q        <= '0;
			mid_z_q        <= '0;
			scale_q        <= '0;
			degenerate_q   <= 1'b1;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						if (!is_xform) begin
							if (head_x < low_x_q)  low_x_q  <= head_x;
							if (head_y < low_y_q)  low_y_q  <= head_y;
							if (head_z < low_z_q)  low_z_q  <= head_z;
							if (head_x > high_x_q) high_x_q <= head_x;
							if (head_y > high_y_q) high_y_q <= head_y;
							if (head_z > high_z_q) high_z_q <= head_z;
							if (head.kind == CMD_MEAS_END) begin
								state_q <= S_SPAN;
							end
						end else if (degenerate_q) begin
							result_valid_q <= 1'b1;
						end else begin
							axis_q  <= AX_X;
							state_q <= S_DIFF;
						end
					end
				end
				S_SPAN: begin
					mid_x_q <= CW'(({low_x_q[CW-1], low_x_q} + {high_x_q[CW-1], high_x_q}) >>> 1);
					mid_y_q <= CW'(({low_y_q[CW-1], low_y_q} + {high_y_q[CW-1], high_y_q}) >>> 1);
					mid_z_q <= CW'(({low_z_q[CW-1], low_z_q} + {high_z_q[CW-1], high_z_q}) >>> 1);
					state_q <= S_PICK;
				end
				S_PICK: begin
					cnt_q <= '0;
					if (is_deg) begin
						degenerate_q <= 1'b1;
						scale_q      <= '0;
						state_q      <= S_IDLE;
					end else begin
						degenerate_q <= 1'b0;
						state_q      <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SW - 1)) begin
						scale_q <= {num_q[SW-2:0], div_ge};
						state_q <= S_IDLE;
					end
				end
				S_DIFF: begin
					state_q <= S_ABS;
				end
				S_ABS: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NCH)) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					if (axis_q == AX_Z) begin
						state_q <= S_EMIT;
					end else begin
						axis_q  <= axis_nx;
						state_q <= S_DIFF;
					end
				end
				S_EMIT: begin
					result_valid_q <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (do_clear) begin
				low_x_q      <= POS_MAX;
				low_y_q      <= POS_MAX;
				low_z_q      <= POS_MAX;
				high_x_q     <= NEG_MAX;
				high_y_q     <= NEG_MAX;
				high_z_q     <= NEG_MAX;
				mid_x_q      <= '0;
				mid_y_q      <= '0;
				mid_z_q      <= '0;
				scale_q      <= '0;
				degenerate_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (head.valid && is_xform) begin
					v_x_q  <= head_x;
					v_y_q  <= head_y;
					v_z_q  <= head_z;
					last_q <= is_last;
					if (degenerate_q) begin
						x_out          <= head_x;
						y_out          <= head_y;
						z_out          <= head_z;
						passed_through <= 1'b1;
						final_vertex   <= is_last;
					end
				end
			end
			S_SPAN: begin
				span_x_q <= {high_x_q[CW-1], high_x_q} - {low_x_q[CW-1], low_x_q};
				span_y_q <= {high_y_q[CW-1], high_y_q} - {low_y_q[CW-1], low_y_q};
				span_z_q <= {high_z_q[CW-1], high_z_q} - {low_z_q[CW-1], low_z_q};
			end
			S_PICK: begin
				rem_q <= '0;
				num_q <= {target_extent, {FB{1'b0}}};
				div_q <= e_max[CW-1:0];
			end
			S_DIV: begin
				rem_q <= div_rem;
				num_q <= {num_q[SW-2:0], div_ge};
			end
			S_DIFF: begin
				d_q <= {v_sel[CW-1], v_sel} - {m_sel[CW-1], m_sel};
			end
			S_ABS: begin
				neg_q <= d_q[CW];
				mag_q <= d_q[CW] ? CW'(-d_q) : d_q[CW-1:0];
				sh_q  <= PW'(scale_q);
				acc_q <= '0;
			end
			S_MUL: begin
				if (cnt_q < CNT_W'(NCH)) begin
					prod_q <= mag_q * chunk;
					sh_q   <= sh_q << MUL_CHUNK;
				end
				if (cnt_q != '0) begin
					acc_q <= (acc_q << MUL_CHUNK) + AW'(prod_q);
				end
			end
			S_SAT: begin
				unique case (axis_q)
					AX_X:    res_x_q <= res;
					AX_Y:    res_y_q <= res;
					default: res_z_q <= res;
				endcase
			end
			S_EMIT: begin
				x_out          <= res_x_q;
				y_out          <= res_y_q;
				z_out          <= res_z_q;
				passed_through <= 1'b0;
				final_vertex   <= last_q;
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;

	a_deg_scale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		degenerate_q |-> (scale_q == '0))
		else $error("scale nonzero while degenerate");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == S_EMIT || (state_q == S_IDLE && head.valid)))
		else $error("result strobe without a transfer source");

	a_scaled_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !passed_through) |-> $past(state_q == S_EMIT))
		else $error("scaled result not from emit");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == CNT_W'(SW - 1)) |=> (state_q == S_IDLE))
		else $error("divider overran its step count");

endmodule

`default_nettype wire

// File: rtl/bounding_box_normalizer_unit.sv
`default_nettype none

// Bounding-box normalizer for a vertex stream in signed fixed point.
// Input: an item transfers when start is high and busy is low. operation 0
// is a measure vertex, 1 a transform vertex; end_of_pass marks the last one.
// Items enter a short queue; busy is high only while that queue is full.
// Output: one result per transform vertex, shown for a single cycle with
// result_valid high. The receiver cannot stall; nothing here waits on it.
// Config: cfg_index 0 target_extent, 1 min_extent; cfg_ready is high only
// while the queue is empty and the engine is idle.
// Steps per item, after it enters the queue:
//   measure vertex: the box bounds update as it leaves the queue.
//   measure end: midpoints and spans are registered, then the box is checked;
//     if not degenerate, the one-bit-per-cycle restoring divider then runs.
//   transform, degenerate model: passed through as it leaves the queue.
//   transform, scaled: per axis difference, magnitude, multiply, saturate, on
//     the single shared 16-bit-slice multiplier, then an emit step.
// Reset: empty box (degenerate, scale 0), registers at 2.0 and 1 LSB,
// queue empty; no clearing pass.

module bounding_box_normalizer_unit #(
	parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = bbn_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = bbn_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic signed [COORD_WIDTH-1:0] x_in,
	input  wire logic signed [COORD_WIDTH-1:0] y_in,
	input  wire logic signed [COORD_WIDTH-1:0] z_in,
	input  wire logic                          end_of_pass,
	output logic                               result_valid,
	output logic signed [COORD_WIDTH-1:0]      x_out,
	output logic signed [COORD_WIDTH-1:0]      y_out,
	output logic signed [COORD_WIDTH-1:0]      z_out,
	output logic                               passed_through,
	output logic                               final_vertex,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [bbn_pkg::REG_W-1:0]     cfg_data
);
	import bbn_pkg::*;

	cmd_ctrl_t                     head;
	logic signed [COORD_WIDTH-1:0] head_x, head_y, head_z;
	logic                          pop;
	logic                          idle;
	logic [REG_W-1:0]              target_extent_q;
	logic [REG_W-1:0]              min_extent_q;

	assign cfg_ready = idle && !head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_extent_q <= TARGET_RESET;
			min_extent_q    <= MIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TARGET_EXTENT: target_extent_q <= cfg_data;
				REG_MIN_EXTENT:    min_extent_q    <= cfg_data;
			endcase
		end
	end

	bbn_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.x_in       (x_in),
		.y_in       (y_in),
		.z_in       (z_in),
		.end_of_pass(end_of_pass),
		.pop        (pop),
		.head       (head),
		.head_x     (head_x),
		.head_y     (head_y),
		.head_z     (head_z)
	);

	bbn_engine #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_x        (head_x),
		.head_y        (head_y),
		.head_z        (head_z),
		.pop           (pop),
		.idle          (idle),
		.target_extent (target_extent_q),
		.min_extent    (min_extent_q),
		.result_valid  (result_valid),
		.x_out         (x_out),
		.y_out         (y_out),
		.z_out         (z_out),
		.passed_through(passed_through),
		.final_vertex  (final_vertex)
	);

endmodule

`default_nettype wire
